>>> src/dtt_pkg.sv
// ============================================================================
// dtt_pkg: shared definitions for the deadline task table
// Entry layout, command codes and status codes.
// ============================================================================
package dtt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] ModeAdd    = 3'd0;
  localparam logic [2:0] ModeLookup = 3'd1;
  localparam logic [2:0] ModeReady  = 3'd2;
  localparam logic [2:0] ModeRemove = 3'd3;
  localparam logic [2:0] ModeSort   = 3'd4;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic        kind;
    logic [31:0] release_t;
    logic [31:0] deadline;
    logic [31:0] completion;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_ctl_t;

endpackage

>>> src/dtt_ram.sv
// ============================================================================
// dtt_ram: entry storage
// One write port and one registered read port.
// ============================================================================
module dtt_ram (
  input  logic              clk_i,
  input  dtt_pkg::mem_ctl_t ctl_i,
  output dtt_pkg::entry_t   rdata_o
);

  dtt_pkg::entry_t mem [dtt_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    rdata_o <= mem[ctl_i.raddr];
  end

endmodule

>>> src/deadline_task_table_top.sv
// ============================================================================
// deadline_task_table_top: earliest-deadline task table
// Sequencer walking the entry RAM one read per step with one shared comparator.
// ============================================================================
//  channel  | handshake          | payload
//  command  | start_i, busy_o    | mode_i, task_id_i, ... current_time_i
//  result   | done_o (one cycle) | status_o, found_*_o
// Add writes the new entry at the end; lookup and next ready read, then compare, each entry scanned.
// Remove scans then shifts the tail, reading and then writing back each entry moved.
// Sort reads entry i then entry j to start each pass, then compares and, when out of order, swaps.
// Reset clears the entry count and the sequencer but not the entry RAM.
// The result port cannot be stalled.
module deadline_task_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] task_id_i,
  input  logic        task_kind_i,
  input  logic [31:0] release_time_i,
  input  logic [31:0] deadline_i,
  input  logic [31:0] completion_time_i,
  input  logic [31:0] current_time_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] found_id_o,
  output logic        found_kind_o,
  output logic [31:0] found_release_o,
  output logic [31:0] found_deadline_o,
  output logic [31:0] found_completion_o
);

  localparam int unsigned IdxW = dtt_pkg::IdxW;
  localparam int unsigned CntW = dtt_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_SHRD, S_SHWR, S_RDI, S_RDJ, S_CMP, S_SWP, S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [2:0]      mode_q, mode_d;
  logic [31:0]     key_q, key_d;
  dtt_pkg::entry_t a_q, a_d, res_q, res_d;
  logic [1:0]      st_q, st_d;
  logic            done_d;
  dtt_pkg::mem_ctl_t ctl;
  dtt_pkg::entry_t rdata, new_e;
  logic            hit;

  dtt_ram u_ram (.clk_i(clk_i), .ctl_i(ctl), .rdata_o(rdata));

  assign new_e = '{id: task_id_i, kind: task_kind_i, release_t: release_time_i,
                   deadline: deadline_i, completion: completion_time_i};

  always_comb begin
    if (mode_q == dtt_pkg::ModeReady) begin
      hit = rdata.release_t <= key_q;
    end else if (mode_q == dtt_pkg::ModeSort) begin
      hit = a_q.deadline > rdata.deadline;
    end else begin
      hit = rdata.id == key_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    i_d = i_q;
    j_d = j_q;
    mode_d = mode_q;
    key_d = key_q;
    a_d = a_q;
    res_d = res_q;
    st_d = st_q;
    done_d = 1'b0;
    ctl = '0;
    ctl.raddr = i_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d = mode_i;
          key_d = (mode_i == dtt_pkg::ModeReady) ? current_time_i : task_id_i;
          i_d = '0;
          j_d = CntW'(1);
          res_d = '0;
          st_d = dtt_pkg::StOk;
          unique case (mode_i) inside
            dtt_pkg::ModeAdd: begin
              if (cnt_q == CntW'(dtt_pkg::TableDepth)) begin
                st_d = dtt_pkg::StFull;
              end else begin
                ctl.we = 1'b1;
                ctl.waddr = cnt_q[IdxW-1:0];
                ctl.wdata = new_e;
                cnt_d = cnt_q + CntW'(1);
              end
              state_d = S_DONE;
            end
            dtt_pkg::ModeLookup, dtt_pkg::ModeReady, dtt_pkg::ModeRemove: begin
              if (cnt_q == '0) begin
                st_d = dtt_pkg::StMiss;
                state_d = S_DONE;
              end else begin
                state_d = S_SRD;
              end
            end
            dtt_pkg::ModeSort: begin
              state_d = (cnt_q > CntW'(1)) ? S_RDI : S_DONE;
            end
            default: begin
              st_d = dtt_pkg::StMiss;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        if (hit) begin
          res_d = rdata;
          if (mode_q == dtt_pkg::ModeRemove) begin
            state_d = S_SHRD;
          end else begin
            state_d = S_DONE;
          end
        end else if (i_q + CntW'(1) == cnt_q) begin
          st_d = dtt_pkg::StMiss;
          state_d = S_DONE;
        end else begin
          i_d = i_q + CntW'(1);
          state_d = S_SRD;
        end
      end
      S_SHRD: begin
        if (i_q + CntW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          ctl.raddr = IdxW'(i_q + CntW'(1));
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.we = 1'b1;
        ctl.waddr = i_q[IdxW-1:0];
        ctl.wdata = rdata;
        i_d = i_q + CntW'(1);
        state_d = S_SHRD;
      end
      S_RDI: begin
        ctl.raddr = i_q[IdxW-1:0];
        state_d = S_RDJ;
      end
      S_RDJ: begin
        a_d = rdata;
        ctl.raddr = j_q[IdxW-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          ctl.we = 1'b1;
          ctl.waddr = i_q[IdxW-1:0];
          ctl.wdata = rdata;
          a_d = rdata;
          state_d = S_SWP;
        end else begin
          state_d = S_SWP;
        end
        if (!hit) begin
          if (j_q + CntW'(1) < cnt_q) begin
            j_d = j_q + CntW'(1);
            ctl.raddr = IdxW'(j_q + CntW'(1));
            state_d = S_CMP;
          end else if (i_q + CntW'(2) < cnt_q) begin
            i_d = i_q + CntW'(1);
            j_d = i_q + CntW'(2);
            state_d = S_RDI;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SWP: begin
        ctl.we = 1'b1;
        ctl.waddr = j_q[IdxW-1:0];
        ctl.wdata = res_q;
        if (j_q + CntW'(1) < cnt_q) begin
          j_d = j_q + CntW'(1);
          ctl.raddr = IdxW'(j_q + CntW'(1));
          state_d = S_CMP;
        end else if (i_q + CntW'(2) < cnt_q) begin
          i_d = i_q + CntW'(1);
          j_d = i_q + CntW'(2);
          state_d = S_RDI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_CMP && hit) begin
      res_d = a_q;
    end
    if (state_d == S_DONE && mode_q == dtt_pkg::ModeSort) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      i_q <= '0;
      j_q <= '0;
      mode_q <= '0;
      key_q <= '0;
      a_q <= '0;
      res_q <= '0;
      st_q <= dtt_pkg::StOk;
      done_o <= 1'b0;
      status_o <= dtt_pkg::StOk;
      found_id_o <= '0;
      found_kind_o <= 1'b0;
      found_release_o <= '0;
      found_deadline_o <= '0;
      found_completion_o <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      i_q <= i_d;
      j_q <= j_d;
      mode_q <= mode_d;
      key_q <= key_d;
      a_q <= a_d;
      res_q <= res_d;
      st_q <= st_d;
      done_o <= done_d;
      if (done_d) begin
        status_o <= st_q;
        found_id_o <= res_q.id;
        found_kind_o <= res_q.kind;
        found_release_o <= res_q.release_t;
        found_deadline_o <= res_q.deadline;
        found_completion_o <= res_q.completion;
      end
    end
  end

  assign busy_o = state_q != S_IDLE;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(dtt_pkg::TableDepth)) else $error("entry count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("command not taken");

endmodule
